// ===== rtl/mbt_pkg.sv =====
// Shared types, codes and helper functions of the maze backtracker step block.
// Has no dependencies; every other file imports it.
package mbt_pkg;

  // Command carried in the input beat.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Result kinds reported in the output beat.
  localparam logic [1:0] ACT_START    = 2'd0;
  localparam logic [1:0] ACT_CARVE    = 2'd1;
  localparam logic [1:0] ACT_BACK     = 2'd2;
  localparam logic [1:0] ACT_COMPLETE = 2'd3;

  // Register indexes on the configuration port (word address bit 2).
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Neighbour directions; the parent memory stores the way back.
  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RD0   = 7'b0000100,
    S_RD1   = 7'b0001000,
    S_RD2   = 7'b0010000,
    S_RD3   = 7'b0100000,
    S_EXEC  = 7'b1000000
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // capture the accepted input beat
    logic clr;     // one step of the visited memory sweep
    logic rd_en;   // read one neighbour of the current room
    dir_t rd_dir;  // which neighbour
    logic exec;    // commit the step and load the output register
  } mbt_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_last;  // sweep is at the last entry
    logic is_start;  // captured command is a start
    logic out_free;  // output register can take a result this cycle
  } mbt_stat_t;

  // Remainder by three: base-4 digits are summed (4 is 1 mod 3), then folded.
  function automatic logic [1:0] mod3(input logic [14:0] v);
    logic [4:0] s;
    logic [2:0] t;
    s = 5'(v[14]);
    for (int i = 0; i < 7; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

endpackage

// ===== rtl/mbt_ctrl.sv =====
// Sequencing state machine of the maze backtracker step block.
// Depends on mbt_pkg for the state, command and status types.
module mbt_ctrl
  import mbt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_cmd,
  output logic      in_tready,
  input  mbt_stat_t st,
  output mbt_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.rd_dir = DIR_LEFT;
    in_tready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) begin
          state_nxt = st.is_start ? S_EXEC : S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_cmd == CMD_START) ? S_CLEAR : S_RD0;
        end
      end
      S_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_dir = DIR_LEFT;
        state_nxt  = S_RD1;
      end
      S_RD1: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_dir = DIR_RIGHT;
        state_nxt  = S_RD2;
      end
      S_RD2: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_dir = DIR_UP;
        state_nxt  = S_RD3;
      end
      S_RD3: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_dir = DIR_DOWN;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        if (st.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/mbt_dpath.sv =====
// Datapath of the maze backtracker step block: visited and parent memories,
// walk position, visit count, neighbour choice and the output register.
// Depends on mbt_pkg; driven by mbt_ctrl through command and status structs.
module mbt_dpath
  import mbt_pkg::*;
#(
  parameter int MAX_SIDE = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [6:0]  grid_width,
  input  logic [6:0]  grid_height,
  input  logic        in_cmd,
  input  logic [14:0] in_rand,
  input  mbt_cmd_t    cmd,
  output mbt_stat_t   st,
  input  logic        out_tready,
  output logic        out_tvalid,
  output logic [1:0]  out_action,
  output logic [5:0]  out_cur_x,
  output logic [5:0]  out_cur_y,
  output logic [5:0]  out_wall_x,
  output logic [5:0]  out_wall_y,
  output logic        out_complete
);

  localparam int ROOMS_SIDE  = (MAX_SIDE + 1) / 2;
  localparam int ROOMS_TOTAL = ROOMS_SIDE * ROOMS_SIDE;
  localparam int CW = (ROOMS_SIDE > 1) ? $clog2(ROOMS_SIDE) : 1;
  localparam int AW = (ROOMS_TOTAL > 1) ? $clog2(ROOMS_TOTAL) : 1;
  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int HW = $clog2(ROOMS_SIDE + 1);
  localparam int NW = $clog2(ROOMS_TOTAL + 1);

  logic            cmd_r;
  logic [1:0]      rnd_lo_r;
  logic [1:0]      rnd_m3_r;
  logic [CW-1:0]   room_x_r, room_y_r;
  logic [NW-1:0]   count_r;
  logic [NW-1:0]   total_r;
  logic [AW-1:0]   clr_cnt_r;
  logic            vis_l_r, vis_rt_r, vis_u_r, vis_rd_r;
  logic [1:0]      par_rd_r;
  logic            vis_mem_r [ROOMS_TOTAL];
  logic [1:0]      par_mem_r [ROOMS_TOTAL];
  logic            out_valid_r;
  logic [1:0]      out_action_r;
  logic [5:0]      out_cur_x_r, out_cur_y_r, out_wall_x_r, out_wall_y_r;
  logic            out_complete_r;

  logic [SW-1:0]   w_cl, h_cl;
  logic [HW-1:0]   w_rooms, h_rooms;
  logic            has_l, has_r, has_u, has_d;
  logic [AW-1:0]   cur_addr, rd_addr, new_addr, vis_waddr;
  logic            vis_we, vis_wdata, par_we;
  logic [3:0]      cand;
  logic [2:0]      n_cand;
  logic [1:0]      k_sel;
  logic [1:0]      pick;
  logic            done;
  logic            carve;
  logic [CW-1:0]   x_nxt, y_nxt;
  logic [1:0]      act_nxt;
  logic [5:0]      wx_nxt, wy_nxt;
  logic            cmpl_nxt;
  logic [NW-1:0]   count_nxt;

  function automatic logic [AW-1:0] room_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
    return AW'(32'(y) * ROOMS_SIDE + 32'(x));
  endfunction

  // Side lengths out of range are clamped into 1..MAX_SIDE.
  always_comb begin
    if (grid_width == 7'd0) begin
      w_cl = SW'(1);
    end else if (32'(grid_width) > MAX_SIDE) begin
      w_cl = SW'(MAX_SIDE);
    end else begin
      w_cl = SW'(grid_width);
    end
    if (grid_height == 7'd0) begin
      h_cl = SW'(1);
    end else if (32'(grid_height) > MAX_SIDE) begin
      h_cl = SW'(MAX_SIDE);
    end else begin
      h_cl = SW'(grid_height);
    end
    w_rooms = HW'((32'(w_cl) + 1) >> 1);
    h_rooms = HW'((32'(h_cl) + 1) >> 1);
  end

  assign has_l = (room_x_r != '0);
  assign has_u = (room_y_r != '0);
  assign has_r = (32'(room_x_r) + 1 < ROOMS_SIDE) && (2 * (32'(room_x_r) + 1) < 32'(w_cl));
  assign has_d = (32'(room_y_r) + 1 < ROOMS_SIDE) && (2 * (32'(room_y_r) + 1) < 32'(h_cl));

  assign cur_addr = room_addr(room_x_r, room_y_r);

  // A neighbour outside the grid reads the current room; its bit is ignored.
  always_comb begin
    rd_addr = cur_addr;
    case (cmd.rd_dir)
      DIR_LEFT:  if (has_l) rd_addr = room_addr(CW'(room_x_r - 1'b1), room_y_r);
      DIR_RIGHT: if (has_r) rd_addr = room_addr(CW'(room_x_r + 1'b1), room_y_r);
      DIR_UP:    if (has_u) rd_addr = room_addr(room_x_r, CW'(room_y_r - 1'b1));
      DIR_DOWN:  if (has_d) rd_addr = room_addr(room_x_r, CW'(room_y_r + 1'b1));
      default:   rd_addr = cur_addr;
    endcase
  end

  // The down neighbour's bit is still in the read register during execute.
  assign cand[0] = has_l & ~vis_l_r;
  assign cand[1] = has_r & ~vis_rt_r;
  assign cand[2] = has_u & ~vis_u_r;
  assign cand[3] = has_d & ~vis_rd_r;
  assign n_cand  = 3'(cand[0]) + 3'(cand[1]) + 3'(cand[2]) + 3'(cand[3]);
  assign done    = (count_r >= total_r);

  always_comb begin
    case (n_cand)
      3'd2:    k_sel = {1'b0, rnd_lo_r[0]};
      3'd3:    k_sel = rnd_m3_r;
      3'd4:    k_sel = rnd_lo_r;
      default: k_sel = 2'd0;
    endcase
  end

  // The k-th free neighbour in the order left, right, up, down.
  always_comb begin
    logic [1:0] seen;
    logic       found;
    seen  = 2'd0;
    found = 1'b0;
    pick  = DIR_LEFT;
    for (int i = 0; i < 4; i++) begin
      if (cand[i] && !found && (seen == k_sel)) begin
        pick  = 2'(i);
        found = 1'b1;
      end
      if (cand[i]) begin
        seen = seen + 2'd1;
      end
    end
  end

  assign carve = (cmd_r == CMD_STEP) && !done && (n_cand != 3'd0);

  always_comb begin
    x_nxt     = room_x_r;
    y_nxt     = room_y_r;
    wx_nxt    = 6'd0;
    wy_nxt    = 6'd0;
    count_nxt = count_r;
    act_nxt   = ACT_COMPLETE;
    cmpl_nxt  = 1'b1;
    if (cmd_r == CMD_START) begin
      x_nxt     = '0;
      y_nxt     = '0;
      count_nxt = NW'(1);
      act_nxt   = ACT_START;
      cmpl_nxt  = (NW'(1) >= total_r);
    end else if (done) begin
      act_nxt = ACT_COMPLETE;
    end else if (carve) begin
      count_nxt = NW'(count_r + 1'b1);
      act_nxt   = ACT_CARVE;
      cmpl_nxt  = (count_nxt >= total_r);
      wx_nxt    = 6'(2 * 32'(room_x_r));
      wy_nxt    = 6'(2 * 32'(room_y_r));
      case (pick)
        DIR_LEFT: begin
          x_nxt  = CW'(room_x_r - 1'b1);
          wx_nxt = 6'(2 * 32'(room_x_r) - 1);
        end
        DIR_RIGHT: begin
          x_nxt  = CW'(room_x_r + 1'b1);
          wx_nxt = 6'(2 * 32'(room_x_r) + 1);
        end
        DIR_UP: begin
          y_nxt  = CW'(room_y_r - 1'b1);
          wy_nxt = 6'(2 * 32'(room_y_r) - 1);
        end
        default: begin
          y_nxt  = CW'(room_y_r + 1'b1);
          wy_nxt = 6'(2 * 32'(room_y_r) + 1);
        end
      endcase
    end else begin
      // Dead end: step back along the stored parent direction if it stays on the array.
      act_nxt  = ACT_BACK;
      cmpl_nxt = 1'b0;
      case (par_rd_r)
        DIR_LEFT:  if (has_l) x_nxt = CW'(room_x_r - 1'b1);
        DIR_RIGHT: if (32'(room_x_r) + 1 < ROOMS_SIDE) x_nxt = CW'(room_x_r + 1'b1);
        DIR_UP:    if (has_u) y_nxt = CW'(room_y_r - 1'b1);
        DIR_DOWN:  if (32'(room_y_r) + 1 < ROOMS_SIDE) y_nxt = CW'(room_y_r + 1'b1);
        default:   x_nxt = room_x_r;
      endcase
    end
  end

  assign new_addr  = room_addr(x_nxt, y_nxt);
  assign par_we    = cmd.exec & carve;
  assign vis_we    = cmd.clr | par_we;
  assign vis_waddr = cmd.clr ? clr_cnt_r : new_addr;
  // A start sweep leaves room 0,0 marked; the sweep after reset leaves it clear.
  assign vis_wdata = cmd.clr ? ((clr_cnt_r == '0) && (cmd_r == CMD_START)) : 1'b1;

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem_r[vis_waddr] <= vis_wdata;
    end
    if (cmd.rd_en) begin
      vis_rd_r <= vis_mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem_r[new_addr] <= pick ^ 2'd1;
    end
    if (cmd.rd_en && (cmd.rd_dir == DIR_LEFT)) begin
      par_rd_r <= par_mem_r[cur_addr];
    end
  end

  // Each read result moves out of the read register as the next read is issued.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      case (cmd.rd_dir)
        DIR_RIGHT: vis_l_r  <= vis_rd_r;
        DIR_UP:    vis_rt_r <= vis_rd_r;
        DIR_DOWN:  vis_u_r  <= vis_rd_r;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    total_r <= NW'(w_rooms) * NW'(h_rooms);
    if (cmd.load) begin
      rnd_lo_r <= in_rand[1:0];
      rnd_m3_r <= mod3(in_rand);
    end
    if (cmd.exec) begin
      out_action_r   <= act_nxt;
      out_cur_x_r    <= 6'(2 * 32'(x_nxt));
      out_cur_y_r    <= 6'(2 * 32'(y_nxt));
      out_wall_x_r   <= wx_nxt;
      out_wall_y_r   <= wy_nxt;
      out_complete_r <= cmpl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r       <= CMD_STEP;
      room_x_r    <= '0;
      room_y_r    <= '0;
      count_r     <= NW'(1);
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        cmd_r <= in_cmd;
      end
      if (cmd.clr) begin
        clr_cnt_r <= st.clr_last ? '0 : AW'(clr_cnt_r + 1'b1);
      end
      if (cmd.exec) begin
        room_x_r    <= x_nxt;
        room_y_r    <= y_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign st.clr_last = (clr_cnt_r == AW'(ROOMS_TOTAL - 1));
  assign st.is_start = (cmd_r == CMD_START);
  assign st.out_free = ~out_valid_r | out_tready;

  assign out_tvalid   = out_valid_r;
  assign out_action   = out_action_r;
  assign out_cur_x    = out_cur_x_r;
  assign out_cur_y    = out_cur_y_r;
  assign out_wall_x   = out_wall_x_r;
  assign out_wall_y   = out_wall_y_r;
  assign out_complete = out_complete_r;

endmodule

// ===== rtl/maze_backtracker_step.sv =====
// Top level of the maze backtracker step block: stream ports, APB-style
// register port, and the controller and datapath instances.
// Depends on mbt_pkg, mbt_ctrl and mbt_dpath.

// This block runs a randomized depth-first maze generator one walk step per
// input beat and returns one result beat for each. Rooms sit at even grid
// coordinates of a maze of grid_width by grid_height squares. A start beat
// clears the visited memory with a sweep of one entry per cycle; the same
// sweep runs once after reset, and no beat is accepted until it ends. A step
// beat is accepted, then the left, right, up and down neighbours are read in
// turn through the single read port of the visited memory (the parent
// direction is read alongside the first), and then a free neighbour is chosen
// or the walk steps back, a carve writes the visited and parent memories, and
// the result is loaded. The result sits in an output register, so the next
// beat is accepted while it waits to be taken; execution of a later step holds
// only while that register is full. The user must write the registers only
// while no beat is in flight; the block itself does not enforce it.
module maze_backtracker_step
  import mbt_pkg::*;
#(
  parameter int MAX_SIDE = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [14:0] rand_value, [15] zero fill
  input  logic        in_tuser,   // [0] cmd
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [5:0] cur_x, [11:6] cur_y, [17:12] wall_x,
                                  // [23:18] wall_y, [24] complete, [31:25] zero
  output logic [1:0]  out_tuser,  // [1:0] action
  // Register port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [6:0]  grid_width_r, grid_height_r;
  logic        cfg_wr;
  mbt_cmd_t    cmd;
  mbt_stat_t   st;
  logic [5:0]  cur_x, cur_y, wall_x, wall_y;
  logic        complete;

  // Registers sit at word addresses; the low two address bits are ignored.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= 7'd64;
      grid_height_r <= 7'd64;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_WIDTH:  grid_width_r  <= cfg_pwdata[6:0];
        REG_HEIGHT: grid_height_r <= cfg_pwdata[6:0];
        default:    ;
      endcase
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_HEIGHT) ? {25'd0, grid_height_r}
                                                   : {25'd0, grid_width_r};

  mbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_tuser),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  mbt_dpath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .grid_width   (grid_width_r),
    .grid_height  (grid_height_r),
    .in_cmd       (in_tuser),
    .in_rand      (in_tdata[14:0]),
    .cmd          (cmd),
    .st           (st),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_action   (out_tuser),
    .out_cur_x    (cur_x),
    .out_cur_y    (cur_y),
    .out_wall_x   (wall_x),
    .out_wall_y   (wall_y),
    .out_complete (complete)
  );

  assign out_tdata = {7'd0, complete, wall_y, wall_x, cur_y, cur_x};

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the maze backtracker step block.
// Depends on mbt_pkg and maze_backtracker_step; holds its own walk predictor.
// Stimulus runs grid settings from one room to beyond the largest maze.

module tb;
  import mbt_pkg::*;

  // Room array of the default build: the grid side is at most 64 squares, so
  // 32 rooms on a side and 1024 rooms in all.
  localparam int SIDE_MAX    = 64;
  localparam int ROOMS_SIDE  = (SIDE_MAX + 1) / 2;
  localparam int ROOMS_TOTAL = ROOMS_SIDE * ROOMS_SIDE;

  // Beats of random stimulus after the directed part.
  localparam int RANDOM_BEATS = 800;
  // The receiver holds off once, for this many cycles, after this many beats.
  localparam int HOLD_AFTER_BEATS = 200;
  localparam int HOLD_CYCLES      = 400;
  // Quiet time at the end: longer than a start, which sweeps the visited memory.
  localparam int DRAIN_CYCLES = 1100;

  // The scoreboard keeps its own copy of the walk: visited rooms, the way back
  // from each room, the current room and the visit count. Every accepted beat
  // is run through it at once, and the move it predicts waits in a queue until
  // the matching result beat comes out.
  class maze_scoreboard;
    typedef struct {
      logic [1:0] action;
      logic [5:0] cur_x;
      logic [5:0] cur_y;
      logic [5:0] wall_x;
      logic [5:0] wall_y;
      logic       complete;
    } move_t;

    logic [6:0] width_reg;
    logic [6:0] height_reg;
    bit         visited [ROOMS_TOTAL];
    dir_t       parent [ROOMS_TOTAL];
    bit         parent_set [ROOMS_TOTAL];
    int         room_x;
    int         room_y;
    int         visit_count;
    move_t      expected_moves [$];
    int         errors;
    int         results_seen;

    function new();
      width_reg   = 7'd64;
      height_reg  = 7'd64;
      room_x      = 0;
      room_y      = 0;
      visit_count = 1;
      errors      = 0;
      results_seen = 0;
      foreach (visited[i]) begin
        visited[i]    = 1'b0;
        parent_set[i] = 1'b0;
      end
    endfunction

    // A side of 0 behaves as 1 and anything past the largest maze as the largest.
    function int clamp_side(logic [6:0] v);
      if (v == 7'd0) return 1;
      if (v > SIDE_MAX) return SIDE_MAX;
      return v;
    endfunction

    function int room_total();
      return ((clamp_side(width_reg) + 1) / 2) * ((clamp_side(height_reg) + 1) / 2);
    endfunction

    function int room_index(int x, int y);
      return (y % ROOMS_SIDE) * ROOMS_SIDE + (x % ROOMS_SIDE);
    endfunction

    // Unvisited neighbours of the current room, in the order left, right, up,
    // down. Left and up only need a nonzero coordinate; right and down must
    // stay inside the grid as the registers now set it.
    function int free_dirs(output dir_t list [4]);
      int n;
      int w;
      int h;
      n = 0;
      w = clamp_side(width_reg);
      h = clamp_side(height_reg);
      if (room_x > 0 && !visited[room_index(room_x - 1, room_y)]) begin
        list[n] = DIR_LEFT;
        n++;
      end
      if (room_x + 1 < ROOMS_SIDE && 2 * (room_x + 1) < w &&
          !visited[room_index(room_x + 1, room_y)]) begin
        list[n] = DIR_RIGHT;
        n++;
      end
      if (room_y > 0 && !visited[room_index(room_x, room_y - 1)]) begin
        list[n] = DIR_UP;
        n++;
      end
      if (room_y + 1 < ROOMS_SIDE && 2 * (room_y + 1) < h &&
          !visited[room_index(room_x, room_y + 1)]) begin
        list[n] = DIR_DOWN;
        n++;
      end
      return n;
    endfunction

    // True when a step now would backtrack through a way-back entry that was
    // never written. The block gives no defined answer there, so the sender
    // turns such a step into a start.
    function bit step_is_unsafe();
      dir_t list [4];
      if (visit_count >= room_total()) return 1'b0;
      if (free_dirs(list) != 0) return 1'b0;
      return !parent_set[room_index(room_x, room_y)];
    endfunction

    // Advance the walk by one accepted beat and queue the move it produces.
    function void note_command(logic cmd, logic [14:0] rnd);
      move_t m;
      dir_t  list [4];
      dir_t  pick;
      int    n;
      int    total;
      int    nx;
      int    ny;
      int    wx;
      int    wy;
      int    r;
      total    = room_total();
      m.wall_x = 6'd0;
      m.wall_y = 6'd0;
      if (cmd == CMD_START) begin
        foreach (visited[i]) visited[i] = 1'b0;
        room_x      = 0;
        room_y      = 0;
        visited[0]  = 1'b1;
        visit_count = 1;
        m.action    = ACT_START;
      end else if (visit_count >= total) begin
        m.action = ACT_COMPLETE;
      end else begin
        n = free_dirs(list);
        if (n == 0) begin
          // Dead end: follow the stored way back, unless it leads off the array.
          case (parent[room_index(room_x, room_y)])
            DIR_LEFT:  if (room_x > 0) room_x--;
            DIR_RIGHT: if (room_x + 1 < ROOMS_SIDE) room_x++;
            DIR_UP:    if (room_y > 0) room_y--;
            default:   if (room_y + 1 < ROOMS_SIDE) room_y++;
          endcase
          m.action = ACT_BACK;
        end else begin
          r    = rnd;
          pick = list[r % n];
          nx   = room_x;
          ny   = room_y;
          wx   = 2 * room_x;
          wy   = 2 * room_y;
          case (pick)
            DIR_LEFT: begin
              nx--;
              wx--;
            end
            DIR_RIGHT: begin
              nx++;
              wx++;
            end
            DIR_UP: begin
              ny--;
              wy--;
            end
            default: begin
              ny++;
              wy++;
            end
          endcase
          visited[room_index(nx, ny)]    = 1'b1;
          parent[room_index(nx, ny)]     = dir_t'(pick ^ 2'd1);
          parent_set[room_index(nx, ny)] = 1'b1;
          room_x = nx;
          room_y = ny;
          visit_count++;
          m.action = ACT_CARVE;
          m.wall_x = 6'(wx);
          m.wall_y = 6'(wy);
        end
      end
      m.cur_x    = 6'(2 * room_x);
      m.cur_y    = 6'(2 * room_y);
      m.complete = (visit_count >= total);
      expected_moves.push_back(m);
    endfunction

    // One line per mismatch, and a running count.
    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task cmp_field(string name, logic [5:0] got, logic [5:0] want);
      if (got !== want) begin
        report($sformatf("result %0d %s got %0d expected %0d", results_seen, name, got, want));
      end
    endtask

    task check_result(logic [1:0] act, logic [31:0] data);
      move_t m;
      results_seen++;
      if (expected_moves.size() == 0) begin
        report($sformatf("result %0d arrived with no step pending", results_seen));
        return;
      end
      m = expected_moves.pop_front();
      cmp_field("action", 6'(act), 6'(m.action));
      cmp_field("cur_x", data[5:0], m.cur_x);
      cmp_field("cur_y", data[11:6], m.cur_y);
      cmp_field("wall_x", data[17:12], m.wall_x);
      cmp_field("wall_y", data[23:18], m.wall_y);
      cmp_field("complete", 6'(data[24]), 6'(m.complete));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;    // [14:0] rand_value, [15] zero fill
  logic        in_tuser;    // [0] cmd
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // [5:0] cur_x, [11:6] cur_y, [17:12] wall_x,
                            // [23:18] wall_y, [24] complete, [31:25] zero
  logic [1:0]  out_tuser;   // [1:0] action
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  maze_scoreboard sb;
  int             accepted_beats = 0;

  maze_backtracker_step u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle lengths: mostly none or a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  // Offer one input beat after 'gap' idle cycles and return once it is taken.
  // Inputs change at the falling edge; tready is sampled at the rising edge.
  // When no gap is asked for, tvalid stays high from the previous beat and only
  // the payload changes, so tvalid sees a single assignment per time step.
  task automatic send_beat(input logic cmd, input logic [14:0] rnd, input int gap);
    logic c;
    c = cmd;
    if (c == CMD_STEP && sb.step_is_unsafe()) c = CMD_START;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= {1'b0, rnd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_command(c, rnd);
    accepted_beats++;
  endtask

  task automatic stop_stream();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Every beat causes exactly one result, so an empty queue means the block
  // has nothing in flight and the registers may be rewritten.
  task automatic wait_drained();
    do @(negedge clk); while (sb.expected_moves.size() != 0);
  endtask

  // One register transfer: a setup cycle, then an access cycle that completes
  // at the rising edge where pready is high. psel drops between
  // back-to-back transfers.
  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Write a register with random upper bits, which the block drops, then read
  // it back.
  task automatic write_reg(input logic idx, input logic [6:0] v);
    logic [31:0] rd;
    apb_access(1'b1, {idx, 2'b00}, {25'($urandom), v}, rd);
    apb_access(1'b0, {idx, 2'b00}, 32'd0, rd);
    if (rd[6:0] !== v) begin
      sb.report($sformatf("register %0d reads back %0d, written %0d", idx, rd[6:0], v));
    end
  endtask

  task automatic set_grid(input logic [6:0] w, input logic [6:0] h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    sb.width_reg  = w;
    sb.height_reg = h;
  endtask

  // Sides at and around the limits: zero and one act as a single room, 65 and
  // up act as the largest maze.
  function automatic logic [6:0] extreme_side();
    case ($urandom_range(0, 6))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd2;
      3:       return 7'd63;
      4:       return 7'd64;
      5:       return 7'd65;
      default: return 7'd127;
    endcase
  endfunction

  function automatic logic [6:0] random_side();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return extreme_side();
    if (r == 1) return 7'($urandom_range(13, 64));
    return 7'($urandom_range(1, 12));
  endfunction

  // Result side. Stalls come in bursts; some stretches have none at all. Once,
  // after enough beats have gone in, the receiver holds off for a long stretch
  // while the sender keeps offering, so the output register fills and the
  // block has to push back on its input.
  initial begin
    int stall_left;
    int mode_left;
    bit calm;
    bit held;
    stall_left = 0;
    mode_left  = 0;
    calm       = 1'b0;
    held       = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && accepted_beats >= HOLD_AFTER_BEATS) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          calm      = ($urandom_range(0, 3) == 0);
          mode_left = $urandom_range(50, 300);
        end
        mode_left--;
        if (stall_left > 0) begin
          out_tready <= 1'b0;
          stall_left--;
        end else if (!calm && $urandom_range(0, 99) < 20) begin
          out_tready <= 1'b0;
          stall_left = pick_gap();
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  // Every result beat taken at a rising edge is checked against the oldest
  // predicted move.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tuser, out_tdata);
    end
  end

  // Stimulus and the final verdict.
  initial begin
    int      steps;
    int      gap;
    bit      calm;
    logic    cmd;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 16'd0;
    in_tuser    = CMD_START;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = 3'd0;
    cfg_pwdata  = 32'd0;
    sb = new();

    // Synchronous reset. The block then clears its visited memory on its own and
    // holds tready low until that sweep is done.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset size of 64 by 64. Stepping before any start
    // walks from room 0,0 without it being marked visited.
    send_beat(CMD_STEP, 15'h0000, 0);
    send_beat(CMD_STEP, 15'h7FFF, 1);
    send_beat(CMD_STEP, 15'h0001, 0);
    send_beat(CMD_START, 15'h7FFF, 0);
    send_beat(CMD_STEP, 15'h0000, 0);
    send_beat(CMD_STEP, 15'h7FFF, 2);
    send_beat(CMD_STEP, 15'h0002, 0);
    send_beat(CMD_STEP, 15'h0003, 0);

    // A single room: the start already completes it and a step reports so.
    stop_stream();
    wait_drained();
    set_grid(7'd1, 7'd1);
    send_beat(CMD_START, 15'h2AAA, 0);
    send_beat(CMD_STEP, 15'h5555, 0);

    // Zero sides act as one.
    stop_stream();
    wait_drained();
    set_grid(7'd0, 7'd0);
    send_beat(CMD_START, 15'h5555, 0);
    send_beat(CMD_STEP, 15'h2AAA, 0);

    // Sides past the limit act as the largest maze.
    stop_stream();
    wait_drained();
    set_grid(7'd127, 7'd127);
    send_beat(CMD_START, 15'h0000, 0);
    send_beat(CMD_STEP, 15'h7FFE, 0);
    send_beat(CMD_STEP, 15'h4000, 0);

    // Four rooms, walked to the end: carving, dead ends that backtrack, and
    // completion.
    stop_stream();
    wait_drained();
    set_grid(7'd3, 7'd3);
    send_beat(CMD_START, 15'h1234, 0);
    repeat (8) send_beat(CMD_STEP, 15'($urandom_range(0, 32767)), 0);

    // Widen the grid in the middle of a walk: the walk picks up the new rooms.
    stop_stream();
    wait_drained();
    set_grid(7'd5, 7'd3);
    repeat (4) send_beat(CMD_STEP, 15'($urandom_range(0, 32767)), 0);

    // Random phases: a grid setting, usually a fresh start, then a walk long
    // enough to finish small mazes, with the odd restart thrown in. Some
    // phases keep the old walk to see it continue under the new registers.
    while (accepted_beats < 30 + RANDOM_BEATS) begin
      stop_stream();
      wait_drained();
      set_grid(random_side(), random_side());
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 85) send_beat(CMD_START, 15'($urandom_range(0, 32767)), 0);
      steps = $urandom_range(4, (2 * sb.room_total() + 8 < 150) ? 2 * sb.room_total() + 8 : 150);
      repeat (steps) begin
        cmd = ($urandom_range(0, 99) < 3) ? CMD_START : CMD_STEP;
        gap = calm ? 0 : pick_gap();
        send_beat(cmd, 15'($urandom_range(0, 32767)), gap);
      end
    end

    // Let every result come out, then stay a while to catch any stray beat.
    stop_stream();
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.expected_moves.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog well past the slowest correct run.
  initial begin
    #8000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== maze_backtracker_step.f =====
rtl/mbt_pkg.sv
rtl/mbt_ctrl.sv
rtl/mbt_dpath.sv
rtl/maze_backtracker_step.sv
verif/tb.sv
